// File: hdl/pvme_pkg.sv
// Shared types and MIDI constants for the voice to MIDI encoder.
package pvme_pkg;

  typedef enum logic [1:0] {
    FUNC_VOICE = 2'd0,
    FUNC_WHEEL = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  localparam logic [7:0]  ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0]  ST_NOTE_ON   = 8'h90;
  localparam logic [7:0]  ST_POLY_PRES = 8'ha0;
  localparam logic [7:0]  ST_CTRL      = 8'hb0;
  localparam logic [7:0]  ST_BEND      = 8'he0;
  localparam logic [6:0]  CC_MOD       = 7'd1;
  localparam logic [13:0] BEND_CENTER  = 14'h2000;
  localparam logic [6:0]  VEL_DEFAULT  = 7'd100;
  localparam logic [6:0]  NOTE_DEFAULT = 7'd60;
  localparam int          MSG_SLOTS    = 3;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } msg_t;

  typedef struct packed {
    msg_t [MSG_SLOTS-1:0] msg;
    logic [1:0]           cnt;
    logic [31:0]          stamp;
  } bundle_t;

endpackage

// File: hdl/poly_voice_to_midi_encoder_top.sv
// Voice to MIDI encoder top level: front end, bundle queue and message sequencer.
// An item's bundle is queued, then its first message loads into the output register.
// Throughput: one input item a cycle while not full; one message a cycle at the output
// while popped; three-message items stall the front once the two-entry queue fills.
// Reset: synchronous rst keeps only pressure/mod values, clears counters and ready.
module poly_voice_to_midi_encoder_top import pvme_pkg::*; #(
  parameter int EVENT_LIMIT    = 128,
  parameter int VOICE_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [3:0]  channel,
  input  logic [6:0]  note,
  input  logic        gate,
  input  logic [6:0]  velocity,
  input  logic [6:0]  pressure,
  input  logic [13:0] pitch_wheel,
  input  logic [6:0]  mod_wheel,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  status_byte,
  output logic [6:0]  data_one,
  output logic [6:0]  data_two,
  output logic [31:0] time_stamp,
  output logic        last
);

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_head;

  assign full = q_full;

  pvme_front #(
    .EVENT_LIMIT    (EVENT_LIMIT),
    .VOICE_CHANNELS (VOICE_CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .func        (func),
    .channel     (channel),
    .note        (note),
    .gate        (gate),
    .velocity    (velocity),
    .pressure    (pressure),
    .pitch_wheel (pitch_wheel),
    .mod_wheel   (mod_wheel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  pvme_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  pvme_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .time_stamp  (time_stamp),
    .last        (last)
  );

endmodule

// File: hdl/pvme_front.sv
// Front end: accepts items, updates voice and wheel state, builds message bundles.
module pvme_front import pvme_pkg::*; #(
  parameter int EVENT_LIMIT    = 128,
  parameter int VOICE_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [1:0] func,
  input  logic [3:0] channel,
  input  logic [6:0] note,
  input  logic       gate,
  input  logic [6:0] velocity,
  input  logic [6:0] pressure,
  input  logic [13:0] pitch_wheel,
  input  logic [6:0] mod_wheel,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  localparam int EW = $clog2(EVENT_LIMIT + 1);
  localparam int CW = (VOICE_CHANNELS > 1) ? $clog2(VOICE_CHANNELS) : 1;
  localparam logic [EW-1:0] LIM = EW'(EVENT_LIMIT);

  logic [6:0]  velocity_store [VOICE_CHANNELS];
  logic [6:0]  note_store     [VOICE_CHANNELS];
  logic        gate_store     [VOICE_CHANNELS];
  logic [6:0]  pressure_store [VOICE_CHANNELS];
  logic        pressure_known [VOICE_CHANNELS];
  logic [6:0]  mod_last;
  logic        mod_known;
  logic [13:0] bend_last;
  logic [EW-1:0] event_count;
  logic [31:0] frame_counter;
  logic        ready_flag;

  logic          acc, in_range, voice_go, wheel_go;
  logic [CW-1:0] idx;
  logic          was, changed, rise, fall, room0;
  logic          do_off, do_on, do_pres, do_bend, do_mod;
  logic [EW-1:0] ec1, ec2, ec3, ew1, ew2;
  logic [6:0]    note_after, cur_note;
  logic          cur_gate, cur_pknown;
  logic [6:0]    cur_pres;
  msg_t [MSG_SLOTS-1:0] m;
  logic [1:0]    cnt;

  assign acc      = push && !q_full;
  assign in_range = {1'b0, channel} < 5'(VOICE_CHANNELS);
  assign idx      = CW'(channel);
  assign voice_go = acc && func == FUNC_VOICE && ready_flag && in_range;
  assign wheel_go = acc && func == FUNC_WHEEL && ready_flag;

  always_comb begin
    cur_note   = in_range ? note_store[idx] : NOTE_DEFAULT;
    cur_gate   = in_range ? gate_store[idx] : 1'b0;
    cur_pres   = in_range ? pressure_store[idx] : 7'd0;
    cur_pknown = in_range ? pressure_known[idx] : 1'b0;
  end

  always_comb begin
    room0      = event_count < LIM;
    was        = cur_gate;
    changed    = gate && was && note != cur_note;
    rise       = gate && !was;
    fall       = !gate && was;
    do_off     = room0 && (changed || fall);
    ec1        = event_count + EW'(do_off);
    do_on      = room0 && (changed || rise) && ec1 < LIM;
    ec2        = ec1 + EW'(do_on);
    note_after = room0 ? note : cur_note;
    do_pres    = !(cur_pknown && cur_pres == pressure) && ec2 < LIM;
    ec3        = ec2 + EW'(do_pres);
    do_bend    = bend_last != pitch_wheel && room0;
    ew1        = event_count + EW'(do_bend);
    do_mod     = !(mod_known && mod_last == mod_wheel) && ew1 < LIM;
    ew2        = ew1 + EW'(do_mod);
  end

  always_comb begin
    m   = '0;
    cnt = 2'd0;
    if (func == FUNC_VOICE) begin
      if (do_off) begin
        m[cnt] = '{ST_NOTE_OFF, cur_note, velocity};
        cnt    = cnt + 2'd1;
      end
      if (do_on) begin
        m[cnt] = '{ST_NOTE_ON, note, velocity};
        cnt    = cnt + 2'd1;
      end
      if (do_pres) begin
        m[cnt] = '{ST_POLY_PRES, note_after, pressure};
        cnt    = cnt + 2'd1;
      end
    end else begin
      if (do_bend) begin
        m[cnt] = '{ST_BEND, pitch_wheel[6:0], pitch_wheel[13:7]};
        cnt    = cnt + 2'd1;
      end
      if (do_mod) begin
        m[cnt] = '{ST_CTRL, CC_MOD, mod_wheel};
        cnt    = cnt + 2'd1;
      end
    end
  end

  assign q_push       = (voice_go || wheel_go) && cnt != 2'd0;
  assign q_data.msg   = m;
  assign q_data.cnt   = cnt;
  assign q_data.stamp = frame_counter;

  always_ff @(posedge clk) begin
    if (rst || (acc && func == FUNC_RESET)) begin
      for (int i = 0; i < VOICE_CHANNELS; i++) begin
        velocity_store[i] <= VEL_DEFAULT;
        note_store[i]     <= NOTE_DEFAULT;
        gate_store[i]     <= 1'b0;
        pressure_known[i] <= 1'b0;
      end
      mod_known     <= 1'b0;
      bend_last     <= BEND_CENTER;
      event_count   <= '0;
      frame_counter <= '0;
      ready_flag    <= 1'b0;
    end else if (acc && func == FUNC_START) begin
      event_count   <= '0;
      frame_counter <= '0;
      ready_flag    <= 1'b1;
    end else if (voice_go) begin
      velocity_store[idx] <= velocity;
      if (room0) begin
        note_store[idx] <= note;
        gate_store[idx] <= gate;
      end
      if (do_pres) begin
        pressure_store[idx] <= pressure;
        pressure_known[idx] <= 1'b1;
      end
      event_count <= ec3;
    end else if (wheel_go) begin
      if (do_bend) bend_last <= pitch_wheel;
      if (do_mod) begin
        mod_last  <= mod_wheel;
        mod_known <= 1'b1;
      end
      event_count   <= ew2;
      frame_counter <= frame_counter + 32'd1;
    end
  end

endmodule

// File: hdl/pvme_queue.sv
// Two-entry bundle queue between the front end and the message sequencer.
module pvme_queue import pvme_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd,
  output logic    empty,
  output bundle_t rd_data
);

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

// File: hdl/pvme_back.sv
// Back end: walks bundles into the output register, one message a cycle while popped.
module pvme_back import pvme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  bundle_t     q_head,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  status_byte,
  output logic [6:0]  data_one,
  output logic [6:0]  data_two,
  output logic [31:0] time_stamp,
  output logic        last
);

  logic       out_valid;
  logic [1:0] idx;
  logic       ld, last_sel;
  msg_t       sel;

  assign ld       = (!out_valid || pop) && !q_empty;
  assign last_sel = idx == q_head.cnt - 2'd1;
  assign sel      = q_head.msg[idx];
  assign q_pop    = ld && last_sel;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (ld) begin
        out_valid <= 1'b1;
        idx       <= last_sel ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      status_byte <= sel.status_byte;
      data_one    <= sel.data_one;
      data_two    <= sel.data_two;
      time_stamp  <= q_head.stamp;
      last        <= last_sel;
    end
  end

endmodule

// File: tb/sv/poly_voice_to_midi_encoder_top_test.sv
// Testbench for the voice to MIDI encoder: directed and random updates checked by a predictor.
`timescale 1ns / 1ps

module poly_voice_to_midi_encoder_top_test;
  import pvme_pkg::*;

  localparam int EVENT_LIMIT    = 128;
  localparam int VOICE_CHANNELS = 16;
  localparam int STALL_LIMIT    = 2000;

  typedef struct {
    func_t       func;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic        gate;
    logic [6:0]  velocity;
    logic [6:0]  pressure;
    logic [13:0] pitch_wheel;
    logic [6:0]  mod_wheel;
  } update_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [31:0] time_stamp;
    logic        last;
  } midi_msg_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  func = FUNC_VOICE;
  logic [3:0]  channel = '0;
  logic [6:0]  note = '0;
  logic        gate = 1'b0;
  logic [6:0]  velocity = '0;
  logic [6:0]  pressure = '0;
  logic [13:0] pitch_wheel = '0;
  logic [6:0]  mod_wheel = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  status_byte;
  logic [6:0]  data_one;
  logic [6:0]  data_two;
  logic [31:0] time_stamp;
  logic        last;

  logic [6:0]  vel_mem [16];
  logic [6:0]  note_mem [16];
  logic        gate_mem [16];
  logic [7:0]  pres_mem [16];
  logic [7:0]  mod_prev;
  logic [13:0] bend_prev;
  int          sent_count;
  logic [31:0] frame;
  bit          armed;

  midi_msg_t   pending_midi [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          hold_off_cycles = 0;
  bit          no_gaps = 1'b0;

  poly_voice_to_midi_encoder_top #(
    .EVENT_LIMIT(EVENT_LIMIT),
    .VOICE_CHANNELS(VOICE_CHANNELS)
  ) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void restore_defaults();
    for (int c = 0; c < 16; c++) begin
      vel_mem[c]  = VEL_DEFAULT;
      note_mem[c] = NOTE_DEFAULT;
      gate_mem[c] = 1'b0;
      pres_mem[c] = 8'hff;
    end
    mod_prev   = 8'hff;
    bend_prev  = BEND_CENTER;
    sent_count = 0;
    frame      = '0;
    armed      = 1'b0;
  endfunction

  function automatic void queue_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    midi_msg_t m;
    m.status_byte = st;
    m.data_one    = d1;
    m.data_two    = d2;
    m.time_stamp  = frame;
    m.last        = 1'b0;
    pending_midi.push_back(m);
    sent_count++;
  endfunction

  function automatic void encode_update(update_t it);
    int   ch;
    int   n;
    logic was;
    logic changed;
    logic rise;
    logic fall;
    ch = it.channel;
    n = pending_midi.size();
    case (it.func)
      FUNC_RESET: restore_defaults();
      FUNC_START: begin
        sent_count = 0;
        frame      = '0;
        armed      = 1'b1;
      end
      FUNC_VOICE: begin
        if (armed && ch < VOICE_CHANNELS) begin
          vel_mem[ch] = it.velocity;
          if (sent_count < EVENT_LIMIT) begin
            was     = gate_mem[ch];
            changed = it.gate && was && it.note != note_mem[ch];
            rise    = it.gate && !was;
            fall    = !it.gate && was;
            if (changed || fall) queue_msg(ST_NOTE_OFF, note_mem[ch], vel_mem[ch]);
            if ((changed || rise) && sent_count < EVENT_LIMIT)
              queue_msg(ST_NOTE_ON, it.note, vel_mem[ch]);
            note_mem[ch] = it.note;
            gate_mem[ch] = it.gate;
          end
          if (pres_mem[ch] != {1'b0, it.pressure} && sent_count < EVENT_LIMIT) begin
            pres_mem[ch] = {1'b0, it.pressure};
            queue_msg(ST_POLY_PRES, note_mem[ch], it.pressure);
          end
        end
      end
      default: begin
        if (armed) begin
          if (bend_prev != it.pitch_wheel && sent_count < EVENT_LIMIT) begin
            bend_prev = it.pitch_wheel;
            queue_msg(ST_BEND, it.pitch_wheel[6:0], it.pitch_wheel[13:7]);
          end
          if (mod_prev != {1'b0, it.mod_wheel} && sent_count < EVENT_LIMIT) begin
            mod_prev = {1'b0, it.mod_wheel};
            queue_msg(ST_CTRL, CC_MOD, it.mod_wheel);
          end
          frame++;
        end
      end
    endcase
    if (pending_midi.size() > n) pending_midi[$].last = 1'b1;
  endfunction

  function automatic update_t make_item(func_t f, int ch, int nt, int g, int vel, int pres,
                                        int pw, int mw);
    update_t it;
    it.func        = f;
    it.channel     = 4'(ch);
    it.note        = 7'(nt);
    it.gate        = 1'(g);
    it.velocity    = 7'(vel);
    it.pressure    = 7'(pres);
    it.pitch_wheel = 14'(pw);
    it.mod_wheel   = 7'(mw);
    return it;
  endfunction

  function automatic update_t random_item(func_t f);
    update_t it;
    it.func        = f;
    it.channel     = 4'($urandom_range(0, 15));
    it.note        = ($urandom_range(0, 3) == 0) ? note_mem[it.channel]
                                                 : 7'($urandom_range(0, 127));
    it.gate        = 1'($urandom_range(0, 1));
    it.velocity    = 7'($urandom_range(0, 127));
    it.pressure    = ($urandom_range(0, 2) == 0) ? pres_mem[it.channel][6:0]
                                                 : 7'($urandom_range(0, 127));
    it.pitch_wheel = ($urandom_range(0, 2) == 0) ? bend_prev : 14'($urandom_range(0, 16383));
    it.mod_wheel   = ($urandom_range(0, 2) == 0) ? mod_prev[6:0] : 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic push_update(update_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push        <= 1'b1;
    func        <= it.func;
    channel     <= it.channel;
    note        <= it.note;
    gate        <= it.gate;
    velocity    <= it.velocity;
    pressure    <= it.pressure;
    pitch_wheel <= it.pitch_wheel;
    mod_wheel   <= it.mod_wheel;
    do @(posedge clk); while (full);
    encode_update(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_midi.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_not_ready();
    push_update(make_item(FUNC_VOICE, 0, 60, 1, 100, 10, 0, 0));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_note_messages();
    push_update(make_item(FUNC_VOICE, 0, 0, 1, 127, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 0, 127, 1, 0, 0, 16383, 127));
    push_update(make_item(FUNC_VOICE, 0, 127, 1, 64, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 0, 127, 0, 1, 127, 0, 0));
    push_update(make_item(FUNC_VOICE, 15, 127, 1, 127, 127, 16383, 127));
    push_update(make_item(FUNC_VOICE, 15, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 7, 5, 0, 3, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_wheels();
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_WHEEL, 15, 127, 1, 127, 127, 0, 0));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, 16383, 127));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, BEND_CENTER, 127));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, 16383, 0));
    wait_drained();
  endtask

  task automatic test_reset_item();
    push_update(make_item(FUNC_VOICE, 2, 64, 1, 50, 20, 0, 0));
    push_update(make_item(FUNC_RESET, 0, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 2, 64, 0, 50, 21, 0, 0));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, 100, 9));
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 2, 64, 0, 50, 21, 0, 0));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, BEND_CENTER, 5));
    wait_drained();
  endtask

  task automatic test_event_budget();
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    while (sent_count < EVENT_LIMIT - 6) push_update(random_item(FUNC_VOICE));
    push_update(make_item(FUNC_VOICE, 5, 40, 1, 90, pres_mem[5][6:0], 0, 0));
    while (sent_count < EVENT_LIMIT - 1)
      push_update(make_item(FUNC_VOICE, 3, note_mem[3], gate_mem[3], 7,
                            pres_mem[3][6:0] ^ 7'h01, 0, 0));
    // one slot left: the note-off goes out, the note-on is dropped
    push_update(make_item(FUNC_VOICE, 5, note_mem[5] ^ 7'h01, 1, 33,
                          pres_mem[5][6:0] ^ 7'h01, 0, 0));
    push_update(make_item(FUNC_VOICE, 5, 17, 0, 44, 3, 0, 0));
    push_update(make_item(FUNC_WHEEL, 0, 0, 0, 0, 0, bend_prev ^ 14'h0001, 3));
    push_update(make_item(FUNC_VOICE, 9, 9, 1, 55, 66, 0, 0));
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    push_update(make_item(FUNC_VOICE, 5, 17, 0, 11, pres_mem[5][6:0], 0, 0));
    wait_drained();
  endtask

  task automatic test_output_stall();
    update_t it;
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    no_gaps = 1'b1;
    hold_off_cycles = 60;
    for (int k = 0; k < 16; k++) begin
      it = random_item(FUNC_VOICE);
      it.pressure = pres_mem[it.channel][6:0] ^ 7'h55;
      push_update(it);
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic(int total);
    int    done;
    int    r;
    bit    paused;
    func_t f;
    done = 0;
    paused = 1'b0;
    push_update(make_item(FUNC_START, 0, 0, 0, 0, 0, 0, 0));
    while (done < total) begin
      no_gaps = ((done / 40) % 3) == 2;
      if (!paused && done >= total / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (!armed)
        f = (r < 70) ? FUNC_START : (r < 80) ? FUNC_RESET : (r < 90) ? FUNC_VOICE : FUNC_WHEEL;
      else
        f = (r < 58) ? FUNC_VOICE : (r < 84) ? FUNC_WHEEL : (r < 88) ? FUNC_RESET : FUNC_START;
      if (armed || f == FUNC_START || f == FUNC_RESET) done++;
      push_update(random_item(f));
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin : drain_results
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 5);
      end
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin : check_results
    midi_msg_t got;
    midi_msg_t want;
    if (!rst && pop && !empty) begin
      got = {status_byte, data_one, data_two, time_stamp, last};
      if (pending_midi.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected MIDI message at %0t: %h %h %h t=%0d last=%b", $time,
                   got.status_byte, got.data_one, got.data_two, got.time_stamp, got.last);
      end else begin
        want = pending_midi.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("MIDI mismatch at %0t: expected %h %h %h t=%0d last=%b, got %h %h %h t=%0d last=%b",
                     $time, want.status_byte, want.data_one, want.data_two, want.time_stamp,
                     want.last, got.status_byte, got.data_one, got.data_two, got.time_stamp,
                     got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    restore_defaults();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_not_ready();
    test_note_messages();
    test_wheels();
    test_reset_item();
    test_event_budget();
    test_output_stall();
    test_random_traffic(100);
    repeat (8) @(posedge clk);
    if (pending_midi.size() != 0) begin
      mismatch_count += pending_midi.size();
      $display("%0d MIDI messages never arrived", pending_midi.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/pvme_pkg.sv
hdl/pvme_front.sv
hdl/pvme_queue.sv
hdl/pvme_back.sv
hdl/poly_voice_to_midi_encoder_top.sv
tb/sv/poly_voice_to_midi_encoder_top_test.sv
